// File: hw/rtl/tlcf_pkg.sv
// Shared types, constants and codes of the text line cell formatter.
package tlcf_pkg;

  localparam int MAX_WIDTH   = 126;
  localparam int MIN_WIDTH   = 20;
  localparam int COLUMN_BITS = 16;
  localparam int TAB_MAX     = 256;

  localparam int CELL_BITS   = 7;
  localparam int BYTE_BITS   = 8;
  localparam int SCROLL_BITS = 16;
  localparam int TAB_BITS    = 9;
  localparam int PHASE_BITS  = 8;
  localparam int ENC_BITS    = 2;
  localparam int INDEX_BITS  = 8;
  localparam int CFG_DATA_BITS = 16;

  localparam int VIS_BITS = ((COLUMN_BITS > SCROLL_BITS) ? COLUMN_BITS : SCROLL_BITS) + 2;
  localparam int ADV_BITS = (COLUMN_BITS > TAB_BITS) ? COLUMN_BITS : TAB_BITS;

  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

  localparam logic [INDEX_BITS-1:0] CFG_WIDTH    = 8'd0;
  localparam logic [INDEX_BITS-1:0] CFG_SCROLL   = 8'd1;
  localparam logic [INDEX_BITS-1:0] CFG_TAB_SIZE = 8'd2;
  localparam logic [INDEX_BITS-1:0] CFG_ENCODING = 8'd3;

  localparam logic [CELL_BITS-1:0]   WIDTH_RESET    = 7'd70;
  localparam logic [SCROLL_BITS-1:0] SCROLL_RESET   = 16'd0;
  localparam logic [TAB_BITS-1:0]    TAB_SIZE_RESET = 9'd4;
  localparam logic [ENC_BITS-1:0]    ENC_ASCII      = 2'd0;
  localparam logic [ENC_BITS-1:0]    ENC_SJIS       = 2'd1;
  localparam logic [ENC_BITS-1:0]    ENC_EUC        = 2'd2;
  localparam logic [ENC_BITS-1:0]    ENC_EUC_ALT    = 2'd3;

  localparam logic [BYTE_BITS-1:0] BYTE_NUL   = 8'h00;
  localparam logic [BYTE_BITS-1:0] BYTE_LF    = 8'h0a;
  localparam logic [BYTE_BITS-1:0] BYTE_TAB   = 8'h09;
  localparam logic [BYTE_BITS-1:0] BYTE_BLANK = 8'h20;
  localparam logic [BYTE_BITS-1:0] SJIS_LO1   = 8'h81;
  localparam logic [BYTE_BITS-1:0] SJIS_HI1   = 8'h9f;
  localparam logic [BYTE_BITS-1:0] SJIS_LO2   = 8'he0;
  localparam logic [BYTE_BITS-1:0] SJIS_HI2   = 8'hfc;
  localparam logic [BYTE_BITS-1:0] EUC_LO     = 8'ha1;
  localparam logic [BYTE_BITS-1:0] EUC_HI     = 8'hfe;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_END   = 2'd2
  } action_t;

  typedef struct packed {
    logic [CELL_BITS-1:0]   width;
    logic [SCROLL_BITS-1:0] scroll;
    logic [TAB_BITS-1:0]    tab_size;
    logic [ENC_BITS-1:0]    encoding;
  } cfg_t;

  typedef struct packed {
    action_t              action;
    logic [CELL_BITS-1:0] column;
    logic [CELL_BITS-1:0] span;
    logic [BYTE_BITS-1:0] byte_value;
    logic [CELL_BITS-1:0] line_length;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t r0;
    result_t r1;
  } step_out_t;

endpackage

// File: hw/rtl/tlcf_step.sv
// Line state registers and the per-byte cell write logic.
module tlcf_step (
  input  logic                           clk,
  input  logic                           rst,
  input  tlcf_pkg::cfg_t                 cfg,
  input  logic                           accept,
  input  logic [tlcf_pkg::BYTE_BITS-1:0] text_byte,
  output tlcf_pkg::step_out_t            step_out
);

  localparam int CB = tlcf_pkg::COLUMN_BITS;
  localparam int VB = tlcf_pkg::VIS_BITS;
  localparam int AB = tlcf_pkg::ADV_BITS;
  localparam int TB = tlcf_pkg::TAB_BITS;
  localparam int PB = tlcf_pkg::PHASE_BITS;
  localparam int WB = tlcf_pkg::CELL_BITS;

  logic [CB-1:0] abs_column, abs_column_next;
  logic [PB-1:0] tab_phase, tab_phase_next;
  logic          lead_pending, lead_pending_next;
  logic [tlcf_pkg::BYTE_BITS-1:0] lead_byte, lead_byte_next;

  logic [WB-1:0] w;
  logic [TB-1:0] t;
  logic signed [VB-1:0] x, ws, wm1, newx, lo, hi;
  logic is_end, is_trail, is_tab, is_lead, is_plain;
  logic [TB-1:0] cnt, n, k;
  logic [CB-1:0] room, col_adv;
  logic [PB-1:0] ph1, ph2, tab_ph;
  tlcf_pkg::result_t r0, r1;
  logic push0, push1;

  always_comb begin
    if (cfg.width < WB'(tlcf_pkg::MIN_WIDTH)) w = WB'(tlcf_pkg::MIN_WIDTH);
    else if (cfg.width > WB'(tlcf_pkg::MAX_WIDTH)) w = WB'(tlcf_pkg::MAX_WIDTH);
    else w = cfg.width;
    if (cfg.tab_size == '0) t = TB'(1);
    else if (cfg.tab_size > TB'(tlcf_pkg::TAB_MAX)) t = TB'(tlcf_pkg::TAB_MAX);
    else t = cfg.tab_size;
  end

  assign x   = $signed(VB'(abs_column)) - $signed(VB'(cfg.scroll));
  assign ws  = $signed(VB'(w));
  assign wm1 = ws - $signed(VB'(1));

  always_comb begin
    is_lead = 1'b0;
    if (cfg.encoding == tlcf_pkg::ENC_SJIS) begin
      is_lead = text_byte inside {[tlcf_pkg::SJIS_LO1:tlcf_pkg::SJIS_HI1],
                                  [tlcf_pkg::SJIS_LO2:tlcf_pkg::SJIS_HI2]};
    end else if (cfg.encoding inside {tlcf_pkg::ENC_EUC, tlcf_pkg::ENC_EUC_ALT}) begin
      is_lead = text_byte inside {[tlcf_pkg::EUC_LO:tlcf_pkg::EUC_HI]};
    end
  end

  assign is_end   = (text_byte == tlcf_pkg::BYTE_NUL) ||
                    (text_byte == tlcf_pkg::BYTE_LF && !lead_pending);
  assign is_trail = !is_end && lead_pending;
  assign is_tab   = !is_end && !lead_pending && text_byte == tlcf_pkg::BYTE_TAB;
  assign is_plain = !is_end && !lead_pending && !is_tab && !is_lead;

  assign cnt  = (TB'(tab_phase) >= t) ? TB'(1) : t - TB'(tab_phase);
  assign n    = is_trail ? TB'(2) : (is_tab ? cnt : (is_plain ? TB'(1) : TB'(0)));
  assign room = '1 - abs_column;
  assign k    = (AB'(n) <= AB'(room)) ? n : TB'(room);
  assign col_adv = abs_column + CB'(k);

  assign ph1    = ((TB'(tab_phase) + TB'(1)) >= t) ? '0 : tab_phase + PB'(1);
  assign ph2    = ((TB'(ph1) + TB'(1)) >= t) ? '0 : ph1 + PB'(1);
  assign tab_ph = (k == cnt) ? '0 : PB'(TB'(tab_phase) + k);

  assign newx = $signed(VB'(col_adv)) - $signed(VB'(cfg.scroll));
  assign lo   = x[VB-1] ? '0 : x;
  assign hi   = (newx > ws) ? ws : newx;

  always_comb begin
    r0 = '{action: tlcf_pkg::ACT_WRITE, column: '0, span: '0, byte_value: '0,
           line_length: '0, last: 1'b0};
    r1 = r0;
    push0 = 1'b0;
    push1 = 1'b0;
    abs_column_next   = abs_column;
    tab_phase_next    = tab_phase;
    lead_pending_next = lead_pending;
    lead_byte_next    = lead_byte;
    if (is_end) begin
      push0 = 1'b1;
      r0.action = tlcf_pkg::ACT_END;
      if (x > ws) r0.line_length = w;
      else if (x[VB-1]) r0.line_length = '0;
      else r0.line_length = x[WB-1:0];
      abs_column_next   = '0;
      tab_phase_next    = '0;
      lead_pending_next = 1'b0;
    end else if (is_trail) begin
      r0.span = WB'(1);
      r1.span = WB'(1);
      if (x == '1) begin
        push0 = 1'b1;
        r0.byte_value = tlcf_pkg::BYTE_BLANK;
      end else if (!x[VB-1] && x < wm1) begin
        push0 = 1'b1;
        push1 = 1'b1;
        r0.column     = x[WB-1:0];
        r0.byte_value = lead_byte;
        r1.column     = x[WB-1:0] + WB'(1);
        r1.byte_value = text_byte;
      end else if (x == wm1) begin
        push0 = 1'b1;
        r0.column     = x[WB-1:0];
        r0.byte_value = tlcf_pkg::BYTE_BLANK;
      end
      abs_column_next   = col_adv;
      tab_phase_next    = (k == TB'(2)) ? ph2 : ((k == TB'(1)) ? ph1 : tab_phase);
      lead_pending_next = 1'b0;
    end else if (is_tab) begin
      if (hi > lo) begin
        push0 = 1'b1;
        r0.action     = tlcf_pkg::ACT_RUN;
        r0.column     = lo[WB-1:0];
        r0.span       = WB'(hi - lo);
        r0.byte_value = tlcf_pkg::BYTE_BLANK;
      end
      abs_column_next = col_adv;
      tab_phase_next  = tab_ph;
    end else if (is_lead) begin
      lead_pending_next = 1'b1;
      lead_byte_next    = text_byte;
    end else begin
      if (!x[VB-1] && x < ws) begin
        push0 = 1'b1;
        r0.column     = x[WB-1:0];
        r0.span       = WB'(1);
        r0.byte_value = text_byte;
      end
      abs_column_next = col_adv;
      tab_phase_next  = (k == TB'(1)) ? ph1 : tab_phase;
    end
    r0.last = !push1;
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_column   <= '0;
      tab_phase    <= '0;
      lead_pending <= 1'b0;
      lead_byte    <= '0;
    end else if (accept) begin
      abs_column   <= abs_column_next;
      tab_phase    <= tab_phase_next;
      lead_pending <= lead_pending_next;
      lead_byte    <= lead_byte_next;
    end
  end

  assign step_out = '{push0: accept && push0, push1: accept && push1, r0: r0, r1: r1};

endmodule

// File: hw/rtl/tlcf_outq.sv
// Result queue: takes up to two results a cycle, hands out one.
module tlcf_outq (
  input  logic                clk,
  input  logic                rst,
  input  tlcf_pkg::step_out_t push,
  output logic                room,
  output logic                m_tvalid,
  input  logic                m_tready,
  output tlcf_pkg::result_t   m_result
);

  localparam int DEPTH = tlcf_pkg::OQ_DEPTH;
  localparam int PW    = tlcf_pkg::OQ_PTR_BITS;
  localparam int CW    = tlcf_pkg::OQ_CNT_BITS;

  tlcf_pkg::result_t entry [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic pop;

  assign m_tvalid = count != '0;
  assign m_result = entry[rptr];
  assign pop      = m_tvalid && m_tready;
  assign room     = count <= CW'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.push0) entry[wptr] <= push.r0;
    if (push.push1) entry[wptr + PW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PW'(push.push0) + PW'(push.push1);
      rptr  <= rptr + PW'(pop);
      count <= count + CW'(push.push0) + CW'(push.push1) - CW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> count <= CW'(DEPTH - 2))
    else $error("result queue overflow on paired write");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> push.push0 && !push.r0.last && push.r1.last)
    else $error("second result without a first one");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    push.push0 && !push.push1 |-> push.r0.last)
    else $error("single result not marked last");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + CW'($past(push.push0)) +
      CW'($past(push.push1)) - CW'($past(pop)))
    else $error("result count out of step");
`endif

endmodule

// File: hw/rtl/text_line_cell_formatter_unit.sv
// Top level of the text line cell formatter.
//
// s_*: one text byte per request in s_tdata[7:0]. 0x0a ends a line, 0x00 ends
// the text. m_*: cell write requests; m_tuser holds the action, m_tlast marks
// the final request caused by one byte. cfg_*: register writes (index 0 width,
// 1 scroll, 2 tab_size, 3 encoding), always ready; write only while idle.
// Throughput: one byte per cycle while s_tready is high. A byte is handled
// in the cycle it is accepted and its requests are registered in the queue.
// A visible double-width pair gives two requests, and the queue's single
// read port hands out one request a cycle while m_tready is high. Lead bytes
// and fully clipped writes give no request; a pair cut by an edge gives one blank.
// A four-entry queue sits between the two sides: s_tready holds high while
// two entries are free, so bytes keep flowing while a request waits on
// m_tready; a longer stall fills the queue and drops s_tready until space
// returns. Reset empties the queue, starts a new line at column zero and
// loads the register defaults (width 70, scroll 0, tab_size 4, ASCII).
module text_line_cell_formatter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // column[6:0], span[13:7], byte_value[21:14],
                                 // line_length[28:22], zero[31:29]
  output logic [1:0]  m_tuser,   // action[1:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tlcf_pkg::INDEX_BITS-1:0]    cfg_index,
  input  logic [tlcf_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  tlcf_pkg::cfg_t      cfg;
  tlcf_pkg::step_out_t step_out;
  tlcf_pkg::result_t   m_result;
  logic room;
  logic accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = room;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width    <= tlcf_pkg::WIDTH_RESET;
      cfg.scroll   <= tlcf_pkg::SCROLL_RESET;
      cfg.tab_size <= tlcf_pkg::TAB_SIZE_RESET;
      cfg.encoding <= tlcf_pkg::ENC_ASCII;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlcf_pkg::CFG_WIDTH:    cfg.width    <= cfg_data[tlcf_pkg::CELL_BITS-1:0];
        tlcf_pkg::CFG_SCROLL:   cfg.scroll   <= cfg_data[tlcf_pkg::SCROLL_BITS-1:0];
        tlcf_pkg::CFG_TAB_SIZE: cfg.tab_size <= cfg_data[tlcf_pkg::TAB_BITS-1:0];
        tlcf_pkg::CFG_ENCODING: cfg.encoding <= cfg_data[tlcf_pkg::ENC_BITS-1:0];
        default: ;
      endcase
    end
  end

  tlcf_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .text_byte (s_tdata),
    .step_out  (step_out)
  );

  tlcf_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (step_out),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (m_result)
  );

  assign m_tdata = {3'b000, m_result.line_length, m_result.byte_value,
                    m_result.span, m_result.column};
  assign m_tuser = m_result.action;
  assign m_tlast = m_result.last;

endmodule
